// ===== hw/rtl/irt_pkg.sv =====
// shared types and constants for the interval reservation table
package irt_pkg;

  localparam int TIME_W       = 32;
  localparam int OCC_W        = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } irt_status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } irt_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] req_start;
    logic [TIME_W-1:0] req_end;
  } irt_in_t;

  typedef struct packed {
    irt_status_t      status;
    logic [OCC_W-1:0] occupancy;
  } irt_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] ival_start;
    logic [TIME_W-1:0] ival_end;
  } irt_entry_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } irt_ctrl_t;

endpackage

// ===== hw/rtl/irt_cell.sv =====
// one table slot: compares against a request and shifts up on insert
module irt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  irt_pkg::irt_ctrl_t ctrl,
  input  irt_pkg::irt_in_t   req_cmp,
  input  irt_pkg::irt_in_t   req_ins,
  input  logic [CNT_W-1:0]   cnt,
  input  irt_pkg::irt_entry_t prev_entry,
  input  logic               prev_after,
  output irt_pkg::irt_entry_t entry,
  output logic               after,
  output logic               ovl
);

  irt_pkg::irt_entry_t entry_r;
  logic                after_r;
  logic                ovl_r;
  logic                used;

  assign used = CNT_W'(IDX) < cnt;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      ovl_r   <= used && (entry_r.ival_start < req_cmp.req_end)
                      && (entry_r.ival_end > req_cmp.req_start);
      after_r <= !used || (entry_r.ival_start >= req_cmp.req_end);
    end
    if (ctrl.upd_en && after_r) begin
      if (prev_after) begin
        entry_r <= prev_entry;
      end else begin
        entry_r.ival_start <= req_ins.req_start;
        entry_r.ival_end   <= req_ins.req_end;
      end
    end
  end

  assign entry = entry_r;
  assign after = after_r;
  assign ovl   = ovl_r;

endmodule

// ===== hw/rtl/interval_reservation_table_core.sv =====
// top level of the interval reservation table
//
//   channel | ports                   | handshake
//   --------+-------------------------+----------------------------------
//   input   | start, busy, in_data    | beat taken when start && !busy
//   result  | out_valid, out_data     | one-cycle strobe, no back pressure
//
// for each item, every cell compares the request at the accept edge,
// the insertion shift and the result register load on the next edge.
// out_valid is high in the cycle after that; start is taken again from then on.
// reset empties the table at once, there is no clearing pass.
// the receiver cannot stall, so results are never held back.
module interval_reservation_table_core #(
  parameter int CAPACITY = irt_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  irt_pkg::irt_in_t in_data,
  output logic             out_valid,
  output irt_pkg::irt_out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  irt_pkg::irt_state_t  state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  irt_pkg::irt_in_t     req_r;
  logic                 invalid_r;
  logic                 out_valid_r;
  irt_pkg::irt_out_t    out_data_r;
  irt_pkg::irt_status_t status;
  irt_pkg::irt_ctrl_t   ctrl;
  irt_pkg::irt_entry_t  cell_q [CAPACITY];
  logic [CAPACITY-1:0]  after_v;
  logic [CAPACITY-1:0]  ovl_v;
  logic                 full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      irt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .req_cmp    (in_data),
        .req_ins    (req_r),
        .cnt        (cnt_r),
        .prev_entry ({req_r.req_start, req_r.req_end}),
        .prev_after (1'b0),
        .entry      (cell_q[i]),
        .after      (after_v[i]),
        .ovl        (ovl_v[i])
      );
    end else begin : g_body
      irt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .req_cmp    (in_data),
        .req_ins    (req_r),
        .cnt        (cnt_r),
        .prev_entry (cell_q[i-1]),
        .prev_after (after_v[i-1]),
        .entry      (cell_q[i]),
        .after      (after_v[i]),
        .ovl        (ovl_v[i])
      );
    end
  end

  assign full = cnt_r == CNT_W'(CAPACITY);

  always_comb begin
    if (invalid_r) begin
      status = irt_pkg::ST_INVALID;
    end else if (|ovl_v) begin
      status = irt_pkg::ST_OVERLAP;
    end else if (full) begin
      status = irt_pkg::ST_FULL;
    end else begin
      status = irt_pkg::ST_BOOKED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irt_pkg::S_IDLE: begin
        if (start) state_nxt = irt_pkg::S_UPDATE;
      end
      irt_pkg::S_UPDATE: begin
        state_nxt = irt_pkg::S_IDLE;
      end
      default: state_nxt = irt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.upd_en = 1'b0;
    case (state_r)
      irt_pkg::S_IDLE: begin
        ctrl.cmp_en = start;
      end
      irt_pkg::S_UPDATE: begin
        busy        = 1'b1;
        ctrl.upd_en = status == irt_pkg::ST_BOOKED;
      end
      default: busy = 1'b0;
    endcase
  end

  assign cnt_nxt = ctrl.upd_en ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= state_r == irt_pkg::S_UPDATE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      req_r     <= in_data;
      invalid_r <= in_data.req_end <= in_data.req_start;
    end
    if (state_r == irt_pkg::S_UPDATE) begin
      out_data_r.status    <= status;
      out_data_r.occupancy <= irt_pkg::OCC_W'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("no result after update cycle");

  a_no_overlap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_booked_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == irt_pkg::ST_BOOKED
      |-> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("booked without count increment");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != irt_pkg::ST_BOOKED |-> $stable(cnt_r))
    else $error("refused request changed count");

endmodule

// ===== dv/tb_interval_reservation_table_core.sv =====
// testbench for interval_reservation_table_core checked against a table predictor
`timescale 1ns / 100ps

module tb_interval_reservation_table_core;

  localparam int CAP = irt_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 235;
  localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  irt_pkg::irt_in_t in_data = '0;
  logic out_valid;
  irt_pkg::irt_out_t out_data;

  irt_pkg::irt_in_t pending_requests[$];
  irt_pkg::irt_out_t expected_outcomes[$];
  irt_pkg::irt_entry_t booked[CAP];
  int booked_count = 0;
  int pending_beats = 0;
  int idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  interval_reservation_table_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // books a valid, non-overlapping request into the predicted table if it is not full, and returns the expected result
  function automatic irt_pkg::irt_out_t book_request(input irt_pkg::irt_in_t req);
    irt_pkg::irt_out_t res;
    int slot;
    int i;
    bit clash;
    res.status = irt_pkg::ST_BOOKED;
    slot = booked_count;
    clash = 1'b0;
    if (req.req_end <= req.req_start) begin
      res.status = irt_pkg::ST_INVALID;
    end else begin
      for (i = 0; i < booked_count; i++) begin
        if (booked[i].ival_start < req.req_end && booked[i].ival_end > req.req_start)
          clash = 1'b1;
        if (slot == booked_count && booked[i].ival_start >= req.req_end) slot = i;
      end
      if (clash) begin
        res.status = irt_pkg::ST_OVERLAP;
      end else if (booked_count >= CAP) begin
        res.status = irt_pkg::ST_FULL;
      end else begin
        for (i = booked_count; i > slot; i--) booked[i] = booked[i-1];
        booked[slot].ival_start = req.req_start;
        booked[slot].ival_end = req.req_end;
        booked_count++;
      end
    end
    res.occupancy = irt_pkg::OCC_W'(booked_count);
    return res;
  endfunction

  task automatic push_request(input longint unsigned s, input longint unsigned e);
    irt_pkg::irt_in_t req;
    req.req_start = s[irt_pkg::TIME_W-1:0];
    req.req_end = e[irt_pkg::TIME_W-1:0];
    pending_requests.push_back(req);
    pending_beats++;
  endtask

  // length in 1..lim, spread over many magnitudes
  function automatic longint unsigned rand_len(input longint unsigned lim);
    longint unsigned span;
    span = 64'd1 << $urandom_range(0, 32);
    if (span > lim) span = lim;
    return 64'd1 + ({32'd0, $urandom()} % span);
  endfunction

  task automatic plan_random_requests(input int count);
    int n;
    int k;
    int g;
    int roll;
    longint unsigned a;
    longint unsigned b;
    longint unsigned s;
    longint unsigned e;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p;
    n = booked_count;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      a = {32'd0, $urandom()};
      b = {32'd0, $urandom()};
      if ($urandom_range(0, 1) == 0) begin
        s = a < b ? a : b;
        e = a < b ? b : a;
      end else begin
        s = $urandom_range(0, 1000);
        e = s + $urandom_range(0, 200);
      end
      if (roll < 8) begin
        s = a > b ? a : b;
        e = $urandom_range(0, 1) ? s : (a > b ? b : a);
      end else if (roll < 20) begin
        // wide or small random span, already set
      end else if (roll < 32) begin
        g = $urandom_range(0, n);
        lo = (g == 0) ? 64'd0 : {32'd0, booked[g-1].ival_end};
        hi = (g == n) ? TIME_MAX : {32'd0, booked[g].ival_start};
        if (hi > lo) begin
          case ($urandom_range(0, 7))
            0: begin
              s = lo;
              e = hi;
            end
            1, 2: begin
              s = lo;
              e = lo + rand_len(hi - lo);
            end
            3, 4: begin
              e = hi;
              s = hi - rand_len(hi - lo);
            end
            default: begin
              s = lo + rand_len(hi - lo) - 1;
              e = s + rand_len(hi - s);
            end
          endcase
        end
      end else if (n > 0) begin
        k = $urandom_range(0, n - 1);
        p = {32'd0, booked[k].ival_start};
        p = p + rand_len({32'd0, booked[k].ival_end} - p) - 1;
        s = p - (rand_len(p + 1) - 1);
        e = p + rand_len(TIME_MAX - p);
      end
      push_request(s, e);
    end
  endtask

  task automatic drain();
    while (pending_beats != 0 || expected_outcomes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(book_request(in_data));
        pending_beats--;
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    irt_pkg::irt_out_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, status %0d occupancy %0d",
                                  out_data.status, out_data.occupancy));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
        if (out_data.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    out_data.occupancy, want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int idle_plan[8];
    idle_plan = '{0, 72, 18, 0, 72, 18, 0, 72};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_request(0, 0);
    push_request(5, 3);
    push_request(TIME_MAX, TIME_MAX);
    push_request(TIME_MAX, 0);
    push_request(100, 200);
    push_request(200, 300);
    push_request(50, 100);
    push_request(150, 250);
    push_request(199, 201);
    push_request(0, 50);
    push_request(10, 20);
    push_request(0, TIME_MAX);
    push_request(TIME_MAX - 1, TIME_MAX);
    push_request(300, 400);
    push_request(250, 250);
    push_request(299, 300);
    push_request(400, 401);
    push_request(TIME_MAX - 2, TIME_MAX);
    push_request(64'h8000_0000, 64'h8000_0001);
    push_request(64'h7FFF_FFFF, 64'h8000_0000);
    push_request(64'h5555_5555, 64'hAAAA_AAAA);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      idle_pct = idle_plan[phase];
      plan_random_requests(PHASE_ITEMS);
      drain();
    end

    idle_pct = 0;
    repeat (8) @(posedge clk);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/irt_pkg.sv
hw/rtl/irt_cell.sv
hw/rtl/interval_reservation_table_core.sv
dv/tb_interval_reservation_table_core.sv
